/* rtl/core/lkv_pkg.sv */
`timescale 1ns / 1ps

package lkv_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W = $clog2(ENTRIES);
	localparam int AGE_W = IDX_W;
	localparam int OCC_W = IDX_W + 1;
	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int CAP_W = 5;
	localparam int CMP_W = (CAP_W > OCC_W) ? CAP_W : OCC_W;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	localparam logic REQ_LOOKUP = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_FINISH,
		S_UPDATE,
		S_RESULT
	} lkv_state_t;

	typedef struct packed {
		logic capture;
		logic scan_step;
		logic update;
		logic load_result;
	} lkv_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic out_free;
	} lkv_status_t;

endpackage

/* rtl/core/lkv_req_if.sv */
`timescale 1ns / 1ps

interface lkv_req_if;
	logic valid;
	logic ready;
	logic req_type;
	logic [31:0] req_key;
	logic [31:0] req_value;

	modport source (output valid, output req_type, output req_key, output req_value,
		input ready);
	modport sink (input valid, input req_type, input req_key, input req_value,
		output ready);
endinterface

/* rtl/core/lkv_rsp_if.sv */
`timescale 1ns / 1ps

interface lkv_rsp_if;
	logic valid;
	logic ready;
	logic found;
	logic [31:0] read_value;
	logic evicted;

	modport source (output valid, output found, output read_value, output evicted,
		input ready);
	modport sink (input valid, input found, input read_value, input evicted,
		output ready);
endinterface

/* rtl/core/lru_key_value_cache.sv */
`timescale 1ns / 1ps

// Fully associative key-value cache with least-recently-used replacement.
// Requests arrive on req (valid/ready): req_type 0 looks up req_key, 1 writes
// req_key with req_value. Each request yields exactly one item on rsp:
// found tells whether the key was present, read_value carries the stored
// value on a lookup hit (0 otherwise), evicted marks a write that dropped the
// least recent entry. cfg_we/cfg_data set the capacity in use; 0 acts as 1
// and values above the entry count act as the entry count. Write it only
// while no request is in flight.
// After acceptance the key memory is swept one entry per cycle over every
// entry, followed by a compare state; the update state then writes the ages
// and memories and the result state loads the result register. A new
// request is taken in the cycle after the result is loaded, so the block
// accepts no new request until the previous one has its result loaded.
// If the receiver stalls, the result waits in the output register; the next
// request is accepted and searched meanwhile, and it stalls only when its own
// result is ready to load. Reset empties the cache and sets capacity to 16.
module lru_key_value_cache
	import lkv_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_data,
	lkv_req_if.sink          req,
	lkv_rsp_if.source        rsp
);

	lkv_cmd_t    cmd;
	lkv_status_t status;

	lkv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.status    (status),
		.cmd       (cmd)
	);

	lkv_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.in_type     (req.req_type),
		.in_key      (req.req_key),
		.in_value    (req.req_value),
		.cmd         (cmd),
		.status      (status),
		.out_ready   (rsp.ready),
		.out_valid   (rsp.valid),
		.out_found   (rsp.found),
		.out_value   (rsp.read_value),
		.out_evicted (rsp.evicted)
	);

endmodule

/* rtl/core/lkv_ram.sv */
`timescale 1ns / 1ps

module lkv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/core/lkv_ctrl.sv */
`timescale 1ns / 1ps

module lkv_ctrl
	import lkv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  lkv_status_t status,
	output lkv_cmd_t    cmd
);

	lkv_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_SEARCH;
			end
			S_SEARCH: begin
				if (status.scan_last) state_d = S_FINISH;
			end
			S_FINISH: state_d = S_UPDATE;
			S_UPDATE: state_d = S_RESULT;
			S_RESULT: begin
				if (status.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				cmd.capture = req_valid;
			end
			S_SEARCH: cmd.scan_step = 1'b1;
			S_FINISH: ;
			S_UPDATE: cmd.update = 1'b1;
			S_RESULT: cmd.load_result = status.out_free;
			default: ;
		endcase
	end

endmodule

/* rtl/core/lkv_datapath.sv */
`timescale 1ns / 1ps

module lkv_datapath
	import lkv_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_data,
	input  logic             in_type,
	input  logic [KEY_W-1:0] in_key,
	input  logic [VAL_W-1:0] in_value,
	input  lkv_cmd_t         cmd,
	output lkv_status_t      status,
	input  logic             out_ready,
	output logic             out_valid,
	output logic             out_found,
	output logic [VAL_W-1:0] out_value,
	output logic             out_evicted
);

	logic [CAP_W-1:0] cap_q;
	logic             req_type_q;
	logic [KEY_W-1:0] req_key_q;
	logic [VAL_W-1:0] req_value_q;

	logic [ENTRIES-1:0] valid_q;
	logic [AGE_W-1:0]   age_q [ENTRIES];
	logic [OCC_W-1:0]   occ_q;

	logic [IDX_W-1:0] scan_idx_q;
	logic             cmp_s1;
	logic [IDX_W-1:0] idx_s1;

	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic [AGE_W-1:0] hit_age_q;
	logic [IDX_W-1:0] victim_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_idx_q;
	logic             res_evicted_q;

	logic             out_valid_q;
	logic             out_found_q;
	logic [VAL_W-1:0] out_value_q;
	logic             out_evicted_q;

	logic [KEY_W-1:0] key_rdata;
	logic [VAL_W-1:0] val_rdata;

	logic             vld_sel;
	logic [AGE_W-1:0] age_sel;
	logic [AGE_W-1:0] oldest_age;
	logic [CAP_W-1:0] eff_cap;
	logic             evict_now;
	logic [IDX_W-1:0] ins_slot;
	logic             do_hit;
	logic             do_insert;
	logic             val_we;
	logic [IDX_W-1:0] val_waddr;
	logic             val_re;

	assign vld_sel = valid_q[idx_s1];
	assign age_sel = age_q[idx_s1];
	// Ages of valid entries are 0 .. occupancy-1, so the oldest one holds occupancy-1.
	assign oldest_age = AGE_W'(occ_q - OCC_W'(1));
	assign eff_cap = (cap_q == '0) ? CAP_W'(1) : cap_q;
	assign evict_now = (CMP_W'(occ_q) >= CMP_W'(eff_cap)) || (occ_q >= OCC_W'(ENTRIES));
	assign ins_slot = !evict_now ? free_idx_q :
		((free_found_q && free_idx_q < victim_q) ? free_idx_q : victim_q);

	assign do_hit = cmd.update && hit_q;
	assign do_insert = cmd.update && !hit_q && (req_type_q == REQ_WRITE);
	assign val_we = cmd.update && (req_type_q == REQ_WRITE);
	assign val_waddr = hit_q ? hit_idx_q : ins_slot;
	assign val_re = do_hit && (req_type_q == REQ_LOOKUP);

	lkv_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
		.clk   (clk),
		.we    (do_insert),
		.waddr (ins_slot),
		.wdata (req_key_q),
		.re    (cmd.scan_step),
		.raddr (scan_idx_q),
		.rdata (key_rdata)
	);

	lkv_ram #(.WIDTH(VAL_W), .DEPTH(ENTRIES)) u_val_ram (
		.clk   (clk),
		.we    (val_we),
		.waddr (val_waddr),
		.wdata (req_value_q),
		.re    (val_re),
		.raddr (hit_idx_q),
		.rdata (val_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_type_q <= in_type;
			req_key_q <= in_key;
			req_value_q <= in_value;
		end
	end

	// Search sweep: key RAM read at scan_idx_q, compared in the next cycle at idx_s1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			cmp_s1 <= 1'b0;
			idx_s1 <= '0;
			hit_q <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			cmp_s1 <= cmd.scan_step;
			idx_s1 <= scan_idx_q;
			if (cmd.capture) begin
				scan_idx_q <= '0;
				hit_q <= 1'b0;
				free_found_q <= 1'b0;
			end else begin
				if (cmd.scan_step) scan_idx_q <= scan_idx_q + IDX_W'(1);
				if (cmp_s1 && vld_sel && !hit_q && key_rdata == req_key_q) hit_q <= 1'b1;
				if (cmp_s1 && !vld_sel && !free_found_q) free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_s1 && vld_sel && !hit_q && key_rdata == req_key_q) begin
			hit_idx_q <= idx_s1;
			hit_age_q <= age_sel;
		end
		if (cmp_s1 && vld_sel && age_sel == oldest_age) victim_q <= idx_s1;
		if (cmp_s1 && !vld_sel && !free_found_q) free_idx_q <= idx_s1;
		if (cmd.update) res_evicted_q <= do_insert && evict_now;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q <= '0;
			for (int i = 0; i < ENTRIES; i++) age_q[i] <= '0;
		end else if (do_hit) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (IDX_W'(i) == hit_idx_q) begin
					age_q[i] <= '0;
				end else if (valid_q[i] && age_q[i] < hit_age_q) begin
					age_q[i] <= age_q[i] + AGE_W'(1);
				end
			end
		end else if (do_insert) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (IDX_W'(i) == ins_slot) begin
					valid_q[i] <= 1'b1;
					age_q[i] <= '0;
				end else if (evict_now && IDX_W'(i) == victim_q) begin
					valid_q[i] <= 1'b0;
				end else if (valid_q[i]) begin
					age_q[i] <= age_q[i] + AGE_W'(1);
				end
			end
			if (!evict_now) occ_q <= occ_q + OCC_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			out_found_q <= hit_q;
			out_value_q <= (hit_q && req_type_q == REQ_LOOKUP) ? val_rdata : '0;
			out_evicted_q <= res_evicted_q;
		end
	end

	assign status.scan_last = (scan_idx_q == IDX_W'(ENTRIES - 1));
	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_found = out_found_q;
	assign out_value = out_value_q;
	assign out_evicted = out_evicted_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(occ_q))
		else $error("valid count disagrees with occupancy");

	assert property (@(posedge clk) disable iff (!arst_n)
		do_insert && evict_now |=> $stable(occ_q))
		else $error("eviction followed by insert changed occupancy");

	assert property (@(posedge clk) disable iff (!arst_n)
		do_insert && !evict_now |-> !free_found_q == 1'b0)
		else $error("insert without eviction found no free entry");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_result |-> !out_valid_q || out_ready)
		else $error("result loaded over an untaken result");

endmodule
